FILE: rtl/grid_cell_locator_assert.svh
// ----------------------------------------------------------------------------
// Grid cell locator assertion macros
// Concurrent checks sampled on clk and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRID_CELL_LOCATOR_ASSERT_SVH
`define GRID_CELL_LOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GCL_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GCL_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gcl_pkg.sv
// ----------------------------------------------------------------------------
// Grid cell locator package
// Shared widths, register index codes and reset values.
// ----------------------------------------------------------------------------
package gcl_pkg;

    localparam int CFG_INDEX_BITS   = 3;
    localparam int CFG_DATA_BITS    = 32;
    localparam int MIN_BITS         = 32;
    localparam int WIDTH_BITS       = 31;
    localparam int COUNT_FIELD_BITS = 10;
    localparam int COUNTS_BITS      = 30;
    localparam int CELL_BITS        = 10;
    localparam int FLAT_BITS        = 30;
    localparam int NUM_AXES         = 3;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 31'd65536;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MIN_X   = 3'd0,
        REG_MIN_Y   = 3'd1,
        REG_MIN_Z   = 3'd2,
        REG_WIDTH_X = 3'd3,
        REG_WIDTH_Y = 3'd4,
        REG_WIDTH_Z = 3'd5,
        REG_COUNTS  = 3'd6
    } cfg_reg_t;

endpackage

FILE: rtl/gcl_channels.sv
// ----------------------------------------------------------------------------
// Grid cell locator channels
// Valid/ready interfaces for queries, results and register writes.
// ----------------------------------------------------------------------------
interface gcl_pos_if import gcl_pkg::*; #(parameter int COORD_BITS = 32);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface gcl_cell_if import gcl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CELL_BITS-1:0] cell_x;
    logic [CELL_BITS-1:0] cell_y;
    logic [CELL_BITS-1:0] cell_z;
    logic [FLAT_BITS-1:0] flat_index;

    modport source (output valid, output cell_x, output cell_y, output cell_z,
                    output flat_index, input ready);
    modport sink   (input valid, input cell_x, input cell_y, input cell_z,
                    input flat_index, output ready);
endinterface

interface gcl_cfg_if import gcl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/gcl_lane.sv
// ----------------------------------------------------------------------------
// Grid cell locator axis lane
// Offset, pipelined restoring division one quotient bit per stage, clamp.
// ----------------------------------------------------------------------------
module gcl_lane import gcl_pkg::*; #(
    parameter int COORD_BITS = 32,
    parameter int IDX_BITS   = 10
) (
    input  logic                  clk,
    input  logic                  advance,
    input  logic [COORD_BITS-1:0] pos,
    input  logic [COORD_BITS-1:0] min_val,
    input  logic [WIDTH_BITS-1:0] cell_width,
    input  logic [IDX_BITS-1:0]   last_idx,
    output logic [IDX_BITS-1:0]   idx
);

    localparam int SW = WIDTH_BITS + IDX_BITS;
    localparam int CW = (COORD_BITS > SW) ? COORD_BITS : SW;

    logic [COORD_BITS-1:0] rem_reg  [0:IDX_BITS-1];
    logic                  neg_reg  [0:IDX_BITS];
    logic [IDX_BITS-1:0]   q_reg    [1:IDX_BITS];
    logic                  over_reg [1:IDX_BITS];
    logic [IDX_BITS-1:0]   idx_reg;

    // The offset cannot wrap once the position is known not to be below the minimum.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0] <= pos - min_val;
            neg_reg[0] <= ($signed(pos) < $signed(min_val));
        end
    end

    for (genvar j = 1; j <= IDX_BITS; j++)
    begin : g_step
        localparam int BIT = IDX_BITS - j;

        logic [CW-1:0]       rem_ext;
        logic [CW-1:0]       divisor;
        logic                take;
        logic [IDX_BITS-1:0] q_prev;
        logic                over_now;

        assign rem_ext = CW'(rem_reg[j-1]);
        assign divisor = CW'(cell_width) << BIT;
        assign take    = (rem_ext >= divisor);

        if (j == 1)
        begin : g_first
            // A quotient that needs more bits than the index is clamped later.
            assign q_prev   = '0;
            assign over_now = (rem_ext >= (CW'(cell_width) << IDX_BITS));
        end
        else
        begin : g_rest
            assign q_prev   = q_reg[j-1];
            assign over_now = over_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                q_reg[j]    <= q_prev | (IDX_BITS'(take) << BIT);
                neg_reg[j]  <= neg_reg[j-1];
                over_reg[j] <= over_now;
            end
        end

        // The last stage only needs its quotient bit, not the remainder.
        if (j < IDX_BITS)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (advance)
                    rem_reg[j] <= take ? COORD_BITS'(rem_ext - divisor) : rem_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (neg_reg[IDX_BITS])
                idx_reg <= '0;
            else if (over_reg[IDX_BITS] || (q_reg[IDX_BITS] > last_idx))
                idx_reg <= last_idx;
            else
                idx_reg <= q_reg[IDX_BITS];
        end
    end

    assign idx = idx_reg;

endmodule

FILE: rtl/gcl_merge.sv
// ----------------------------------------------------------------------------
// Grid cell locator merge stage
// Combines the per-axis indices into the row-major flat cell number.
// ----------------------------------------------------------------------------
module gcl_merge import gcl_pkg::*; #(
    parameter int IDX_BITS = 10
) (
    input  logic                 clk,
    input  logic                 advance,
    input  logic [IDX_BITS-1:0]  idx_x,
    input  logic [IDX_BITS-1:0]  idx_y,
    input  logic [IDX_BITS-1:0]  idx_z,
    input  logic [IDX_BITS-1:0]  last_y,
    input  logic [IDX_BITS-1:0]  last_z,
    output logic [CELL_BITS-1:0] cell_x,
    output logic [CELL_BITS-1:0] cell_y,
    output logic [CELL_BITS-1:0] cell_z,
    output logic [FLAT_BITS-1:0] flat_index
);

    localparam int PA = 2 * IDX_BITS + 1;
    localparam int PB = 3 * IDX_BITS + 1;

    logic [IDX_BITS:0]     count_y;
    logic [IDX_BITS:0]     count_z;
    logic [PA-1:0]         sum_a;
    logic [PB-1:0]         sum_b;

    logic [2*IDX_BITS-1:0] row_reg;
    logic [IDX_BITS-1:0]   x_a_reg;
    logic [IDX_BITS-1:0]   y_a_reg;
    logic [IDX_BITS-1:0]   z_a_reg;
    logic [CELL_BITS-1:0]  cell_x_reg;
    logic [CELL_BITS-1:0]  cell_y_reg;
    logic [CELL_BITS-1:0]  cell_z_reg;
    logic [FLAT_BITS-1:0]  flat_reg;

    assign count_y = (IDX_BITS+1)'(last_y) + 1'b1;
    assign count_z = (IDX_BITS+1)'(last_z) + 1'b1;
    assign sum_a   = PA'(idx_x) * PA'(count_y) + PA'(idx_y);
    assign sum_b   = PB'(row_reg) * PB'(count_z) + PB'(z_a_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            row_reg    <= sum_a[2*IDX_BITS-1:0];
            x_a_reg    <= idx_x;
            y_a_reg    <= idx_y;
            z_a_reg    <= idx_z;
            cell_x_reg <= CELL_BITS'(x_a_reg);
            cell_y_reg <= CELL_BITS'(y_a_reg);
            cell_z_reg <= CELL_BITS'(z_a_reg);
            flat_reg   <= FLAT_BITS'(sum_b[3*IDX_BITS-1:0]);
        end
    end

    assign cell_x     = cell_x_reg;
    assign cell_y     = cell_y_reg;
    assign cell_z     = cell_z_reg;
    assign flat_index = flat_reg;

endmodule

FILE: rtl/grid_cell_locator.sv
// ----------------------------------------------------------------------------
// Grid cell locator
// Finds the cell of a uniform block grid that holds a fixed-point position.
// ----------------------------------------------------------------------------
// A query transfer on the query channel carries a signed fixed-point position
// per axis. For each one the block returns one result transfer on the result
// channel with the clamped cell index of every axis and the row-major flat
// cell number, x slowest and z fastest. Results leave in query order.
// Every axis has a lane of its own: the offset from the block minimum, then a
// restoring divider by the cell width with one quotient bit per stage, then a
// clamp to the configured count. A merge stage forms the flat number with two
// registered multiply-adds. The pipeline has log2(MAX_AXIS_CELLS) + 4 stages,
// 14 at the default. Throughput is one query per cycle while the result
// channel is not stalled; the divider stages are fully pipelined.
// The pipeline advances whenever the result register is empty or being
// taken, so a stalled receiver holds every stage and query ready falls.
// Register writes wait until the pipeline is empty and no query is offered.
// Reset empties the pipeline and puts the registers to their defaults: a unit
// grid at the origin with one cell on each axis.
// ----------------------------------------------------------------------------
`include "grid_cell_locator_assert.svh"

module grid_cell_locator import gcl_pkg::*; #(
    parameter int AXES           = 3,
    parameter int MAX_AXIS_CELLS = 1024,
    parameter int COORD_BITS     = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    gcl_pos_if.sink    query,
    gcl_cell_if.source result,
    gcl_cfg_if.sink    cfg
);

    localparam int IDX_BITS = $clog2(MAX_AXIS_CELLS);
    localparam int LAT      = IDX_BITS + 4;
    localparam int MW       = (COORD_BITS > MIN_BITS) ? COORD_BITS : MIN_BITS;

    // Register file, written from the configuration channel.
    logic [MIN_BITS-1:0]    min_x_reg;
    logic [MIN_BITS-1:0]    min_y_reg;
    logic [MIN_BITS-1:0]    min_z_reg;
    logic [WIDTH_BITS-1:0]  width_x_reg;
    logic [WIDTH_BITS-1:0]  width_y_reg;
    logic [WIDTH_BITS-1:0]  width_z_reg;
    logic [COUNTS_BITS-1:0] counts_reg;

    logic [LAT-1:0]         valid_reg;
    logic                   advance;

    logic [COORD_BITS-1:0]  pos_a   [NUM_AXES];
    logic [COORD_BITS-1:0]  min_a   [NUM_AXES];
    logic [WIDTH_BITS-1:0]  width_a [NUM_AXES];
    logic [IDX_BITS-1:0]    last_a  [NUM_AXES];
    logic [IDX_BITS-1:0]    idx_a   [NUM_AXES];

    // A write must never change the grid under a query, so it is held off
    // while any stage is busy or a query is being offered.
    assign cfg.ready = !(|valid_reg) && !query.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg   <= '0;
            min_y_reg   <= '0;
            min_z_reg   <= '0;
            width_x_reg <= WIDTH_RESET;
            width_y_reg <= WIDTH_RESET;
            width_z_reg <= WIDTH_RESET;
            counts_reg  <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_MIN_X:   min_x_reg   <= cfg.data[MIN_BITS-1:0];
                REG_MIN_Y:   min_y_reg   <= cfg.data[MIN_BITS-1:0];
                REG_MIN_Z:   min_z_reg   <= cfg.data[MIN_BITS-1:0];
                REG_WIDTH_X: width_x_reg <= cfg.data[WIDTH_BITS-1:0];
                REG_WIDTH_Y: width_y_reg <= cfg.data[WIDTH_BITS-1:0];
                REG_WIDTH_Z: width_z_reg <= cfg.data[WIDTH_BITS-1:0];
                REG_COUNTS:  counts_reg  <= cfg.data[COUNTS_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // The whole pipeline moves as one; the valid chain tracks which stages
    // hold a real query.
    assign advance     = !valid_reg[LAT-1] || result.ready;
    assign query.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[LAT-2:0], query.valid};
    end

    assign pos_a[0] = query.pos_x;
    assign pos_a[1] = query.pos_y;
    assign pos_a[2] = query.pos_z;

    // The minimum registers are zero-extended or cut to the coordinate width.
    assign min_a[0] = COORD_BITS'(MW'(min_x_reg));
    assign min_a[1] = COORD_BITS'(MW'(min_y_reg));
    assign min_a[2] = COORD_BITS'(MW'(min_z_reg));

    assign width_a[0] = width_x_reg;
    assign width_a[1] = width_y_reg;
    assign width_a[2] = width_z_reg;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        if (a < AXES)
        begin : g_used
            logic [COUNT_FIELD_BITS-1:0] field;

            // Counts above the grid limit saturate at the limit.
            assign field     = counts_reg[a*COUNT_FIELD_BITS +: COUNT_FIELD_BITS];
            assign last_a[a] = (field >= COUNT_FIELD_BITS'(MAX_AXIS_CELLS - 1))
                             ? IDX_BITS'(MAX_AXIS_CELLS - 1)
                             : IDX_BITS'(field);

            gcl_lane #(
                .COORD_BITS (COORD_BITS),
                .IDX_BITS   (IDX_BITS)
            ) u_lane (
                .clk        (clk),
                .advance    (advance),
                .pos        (pos_a[a]),
                .min_val    (min_a[a]),
                .cell_width (width_a[a]),
                .last_idx   (last_a[a]),
                .idx        (idx_a[a])
            );
        end
        else
        begin : g_unused
            // An axis beyond the configured number is a single cell.
            assign last_a[a] = '0;
            assign idx_a[a]  = '0;
        end
    end

    gcl_merge #(
        .IDX_BITS   (IDX_BITS)
    ) u_merge (
        .clk        (clk),
        .advance    (advance),
        .idx_x      (idx_a[0]),
        .idx_y      (idx_a[1]),
        .idx_z      (idx_a[2]),
        .last_y     (last_a[1]),
        .last_z     (last_a[2]),
        .cell_x     (result.cell_x),
        .cell_y     (result.cell_y),
        .cell_z     (result.cell_z),
        .flat_index (result.flat_index)
    );

    assign result.valid = valid_reg[LAT-1];

    // Every delivered index lies inside the configured grid.
    `GCL_CHECK(a_cells_in_grid, result.valid, (result.cell_x <= CELL_BITS'(last_a[0])) && (result.cell_y <= CELL_BITS'(last_a[1])) && (result.cell_z <= CELL_BITS'(last_a[2])), "cell index outside the configured grid")

    // A grid of one cell on every axis can only give cell zero.
    `GCL_CHECK(a_single_cell_flat, result.valid && (counts_reg == '0), result.flat_index == '0, "flat index non-zero for a single-cell grid")

    // An x width write lands in its register.
    `GCL_CHECK_NEXT(a_width_x_write, cfg.valid && cfg.ready && (cfg.index == REG_WIDTH_X), width_x_reg == $past(cfg.data[WIDTH_BITS-1:0]), "x cell width not updated by its write")

endmodule

FILE: tb/grid_cell_locator_tb.sv
// ----------------------------------------------------------------------------
// Grid cell locator testbench
// Sends query positions and register writes over the valid/ready channels,
// works out the expected cell indices and flat cell number for every query,
// and checks each result transfer against them in order.
// ----------------------------------------------------------------------------
module grid_cell_locator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import gcl_pkg::*;

    // The block has 14 pipeline stages.
    localparam int PIPE_LATENCY  = 14;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 6;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 62;
    localparam int MAX_BURST     = 13;

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [CELL_BITS-1:0] cell_x;
        logic [CELL_BITS-1:0] cell_y;
        logic [CELL_BITS-1:0] cell_z;
        logic [FLAT_BITS-1:0] flat_index;
    } cell_t;

    localparam cell_t NO_CELL = '0;

    typedef enum logic {ROW_QUERY, ROW_WRITE} row_kind_t;

    // One row of the directed table. A write row carries its data in x and
    // leaves the other fields unused; a query row ignores idx. Where known
    // is set, want is the typed-in result and the predictor is not used.
    typedef struct packed {
        row_kind_t   kind;
        cfg_reg_t    idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        known;
        cell_t       want;
    } row_t;

    localparam int DIRECTED_ROWS = 22;

    row_t directed_rows [DIRECTED_ROWS] = '{
        // Reset grid: one unit cell on every axis, so everything lands in 0.
        '{ROW_QUERY, REG_MIN_X, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, NO_CELL},
        '{ROW_QUERY, REG_MIN_X, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, NO_CELL},
        '{ROW_QUERY, REG_MIN_X, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b1, NO_CELL},
        // All counts at their largest; the two unused top bits are set too.
        '{ROW_WRITE, REG_COUNTS, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, NO_CELL},
        '{ROW_QUERY, REG_MIN_X, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
          '{10'd1023, 10'd1023, 10'd1023, 30'h3FFF_FFFF}},
        '{ROW_QUERY, REG_MIN_X, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, NO_CELL},
        '{ROW_QUERY, REG_MIN_X, 32'h000A_0000, 32'h0014_0000, 32'h001E_0000, 1'b0, NO_CELL},
        '{ROW_QUERY, REG_MIN_X, 32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001, 1'b0, NO_CELL},
        // Shifted minimum on x, extreme minima on y and z.
        '{ROW_WRITE, REG_MIN_X, 32'h0005_0000, 32'h0, 32'h0, 1'b0, NO_CELL},
        '{ROW_WRITE, REG_MIN_Y, 32'h8000_0000, 32'h0, 32'h0, 1'b0, NO_CELL},
        '{ROW_WRITE, REG_MIN_Z, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, NO_CELL},
        '{ROW_QUERY, REG_MIN_X, 32'h0004_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b1,
          '{10'd0, 10'd1023, 10'd0, 30'd1047552}},
        '{ROW_QUERY, REG_MIN_X, 32'h0005_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, NO_CELL},
        '{ROW_QUERY, REG_MIN_X, 32'h0006_0000, 32'h8001_0000, 32'h7FFF_FFFF, 1'b0, NO_CELL},
        // Widest cell on x, finest on y, and a zero width on z (its top bit
        // lies outside the register and must be dropped).
        '{ROW_WRITE, REG_WIDTH_X, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, NO_CELL},
        '{ROW_WRITE, REG_WIDTH_Y, 32'h8000_0001, 32'h0, 32'h0, 1'b0, NO_CELL},
        '{ROW_WRITE, REG_WIDTH_Z, 32'h8000_0000, 32'h0, 32'h0, 1'b0, NO_CELL},
        '{ROW_QUERY, REG_MIN_X, 32'h7FFF_FFFF, 32'h8000_0400, 32'h7FFF_FFFF, 1'b0, NO_CELL},
        '{ROW_QUERY, REG_MIN_X, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFE, 1'b0, NO_CELL},
        // Uneven counts: three cells on x, one on y, six on z.
        '{ROW_WRITE, REG_COUNTS, 32'h0050_0002, 32'h0, 32'h0, 1'b0, NO_CELL},
        '{ROW_QUERY, REG_MIN_X, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, NO_CELL},
        '{ROW_QUERY, REG_MIN_X, 32'h0005_0000, 32'h8000_0001, 32'h8000_0000, 1'b0, NO_CELL}
    };

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   failures    = 0;
    int   cycle_count = 0;

    // Expected results in query order, oldest first.
    cell_t cells_due [$];

    // Our own copy of the grid registers, updated on every write transfer.
    logic [MIN_BITS-1:0]    grid_min   [NUM_AXES] = '{default: '0};
    logic [WIDTH_BITS-1:0]  grid_width [NUM_AXES] = '{default: WIDTH_RESET};
    logic [COUNTS_BITS-1:0] grid_counts = '0;

    gcl_pos_if #(.COORD_BITS(32)) query_ch ();
    gcl_cell_if                   result_ch ();
    gcl_cfg_if                    cfg_ch ();

    grid_cell_locator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic logic [10:0] cells_on_axis(int a);
        return {1'b0, grid_counts[a*COUNT_FIELD_BITS +: COUNT_FIELD_BITS]} + 11'd1;
    endfunction

    // The offset from the minimum is taken at 33 bits so that it cannot
    // wrap; below the minimum the index is 0, and a zero width behaves as an
    // endlessly fine grid, so anything at or past the minimum is the last cell.
    function automatic logic [CELL_BITS-1:0] axis_cell(logic [31:0] pos, int a);
        logic signed [32:0] offset;
        logic [63:0]        quot;
        logic [10:0]        n;
        n      = cells_on_axis(a);
        offset = $signed({pos[31], pos}) - $signed({grid_min[a][31], grid_min[a]});
        if (offset[32])
            return '0;
        if (grid_width[a] == '0)
            return CELL_BITS'(n - 11'd1);
        quot = {31'd0, offset} / {33'd0, grid_width[a]};
        if (quot >= {53'd0, n})
            quot = {53'd0, n - 11'd1};
        return quot[CELL_BITS-1:0];
    endfunction

    function automatic cell_t locate_cell(logic [31:0] px, logic [31:0] py,
                                          logic [31:0] pz);
        cell_t       c;
        logic [63:0] flat;
        c.cell_x = axis_cell(px, 0);
        c.cell_y = axis_cell(py, 1);
        c.cell_z = axis_cell(pz, 2);
        flat = ({54'd0, c.cell_x} * {53'd0, cells_on_axis(1)} + {54'd0, c.cell_y})
               * {53'd0, cells_on_axis(2)} + {54'd0, c.cell_z};
        c.flat_index = flat[FLAT_BITS-1:0];
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Random choices
    // ------------------------------------------------------------------------

    function automatic logic [31:0] pick_min();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            default: return $urandom;
        endcase
    endfunction

    // Bit 31 lies outside the width register; it is set at random throughout.
    function automatic logic [31:0] pick_width();
        case ($urandom_range(0, 9))
            0:          return $urandom & 32'h8000_0000;
            1:          return $urandom | 32'h7FFF_FFFF;
            2:          return ($urandom & 32'h8000_0000) | 32'd1;
            3, 4, 5, 6: return ($urandom & 32'h8000_0000) | $urandom_range(1, 32'h0004_0000);
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic [COUNT_FIELD_BITS-1:0] pick_count();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return COUNT_FIELD_BITS'($urandom_range(1, 15));
            default: return COUNT_FIELD_BITS'($urandom);
        endcase
    endfunction

    // Most positions sit on or next to a cell boundary of the current grid,
    // from one cell below the minimum to one past the last cell; the rest are
    // the coordinate extremes or any value at all.
    function automatic logic [31:0] pick_pos(int a);
        longint      base;
        longint      step;
        longint      p;
        int          k;
        logic [10:0] n;
        n = cells_on_axis(a);
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default:
            begin
                base = longint'($signed(grid_min[a]));
                step = longint'({33'd0, grid_width[a]});
                k    = int'($urandom_range(0, n + 1)) - 1;
                p    = base + k * step;
                case ($urandom_range(0, 3))
                    0:       p = p - 1;
                    1:       ;
                    2:       p = p + 1;
                    default: p = p + ((step > 1) ? longint'($urandom_range(0, step - 1)) : 0);
                endcase
                if (p > POS_MAX)
                    p = POS_MAX;
                if (p < POS_MIN)
                    p = POS_MIN;
                return p[31:0];
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // A query transfer, sometimes after a random gap. The expectation is
    // queued at the very edge that accepts the transfer, while the grid copy
    // is known to match the block.
    task automatic send_query(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic known, cell_t typed);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, MAX_BURST);
            query_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        query_ch.valid <= 1'b1;
        query_ch.pos_x <= px;
        query_ch.pos_y <= py;
        query_ch.pos_z <= pz;
        do
            @(posedge clk);
        while (!(query_ch.valid && query_ch.ready));
        cells_due.push_back(known ? typed : locate_cell(px, py, pz));
    endtask

    // The block only takes writes with nothing in flight, and changing the
    // grid under a query would also break the prediction, so all results
    // are collected first and the pipeline is given time to empty.
    task automatic drain_pipeline();
        @(negedge clk);
        query_ch.valid <= 1'b0;
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        case (idx)
            REG_MIN_X:   grid_min[0]   = value;
            REG_MIN_Y:   grid_min[1]   = value;
            REG_MIN_Z:   grid_min[2]   = value;
            REG_WIDTH_X: grid_width[0] = value[WIDTH_BITS-1:0];
            REG_WIDTH_Y: grid_width[1] = value[WIDTH_BITS-1:0];
            REG_WIDTH_Z: grid_width[2] = value[WIDTH_BITS-1:0];
            REG_COUNTS:  grid_counts   = value[COUNTS_BITS-1:0];
            default:     ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial
    begin : stimulus
        rst_n          = 1'b0;
        idle_on        = 1'b1;
        query_ch.valid = 1'b0;
        query_ch.pos_x = '0;
        query_ch.pos_y = '0;
        query_ch.pos_z = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_MIN_X;
        cfg_ch.data    = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: a run of writes is preceded by a full drain.
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_WRITE)
            begin
                if (r == 0 || directed_rows[r-1].kind == ROW_QUERY)
                    drain_pipeline();
                write_reg(directed_rows[r].idx, directed_rows[r].x);
            end
            else
                send_query(directed_rows[r].x, directed_rows[r].y, directed_rows[r].z,
                           directed_rows[r].known, directed_rows[r].want);
        end

        // Random phases, each on a freshly drawn grid. Idling is off in every
        // third phase and in the last two, so back-to-back traffic is seen too.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_pipeline();
            idle_on = (phase < RANDOM_PHASES - 2) && (phase % 3 != 1);
            write_reg(REG_MIN_X, pick_min());
            write_reg(REG_MIN_Y, pick_min());
            write_reg(REG_MIN_Z, pick_min());
            write_reg(REG_WIDTH_X, pick_width());
            write_reg(REG_WIDTH_Y, pick_width());
            write_reg(REG_WIDTH_Z, pick_width());
            write_reg(REG_COUNTS, {2'($urandom), pick_count(), pick_count(), pick_count()});
            repeat (PHASE_ITEMS)
                send_query(pick_pos(0), pick_pos(1), pick_pos(2), 1'b0, NO_CELL);
        end

        drain_pipeline();
        if (failures == 0 && cells_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Ready is dropped in bursts while idling is on and held high otherwise.
    initial
    begin : result_sink
        int hold;
        hold            = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                result_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, MAX_BURST) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        cell_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (cells_due.size() == 0)
            begin
                $error("result transfer with no query outstanding");
                failures++;
            end
            else
            begin
                want = cells_due.pop_front();
                check_field("cell_x", want.cell_x, result_ch.cell_x);
                check_field("cell_y", want.cell_y, result_ch.cell_y);
                check_field("cell_z", want.cell_z, result_ch.cell_z);
                check_field("flat_index", want.flat_index, result_ch.flat_index);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
